@@ src/arect_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Animated rectangle evaluator package
// Shared sizes, property codes and value types.
// ----------------------------------------------------------------------------
package arect_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int NODE_W = 8;
  localparam int PROP_W = 3;
  localparam int NCNT_W = 9;
  localparam int TIME_W = 32;

  localparam logic [PROP_W-1:0] PROP_X      = 3'd0;
  localparam logic [PROP_W-1:0] PROP_Y      = 3'd1;
  localparam logic [PROP_W-1:0] PROP_WIDTH  = 3'd2;
  localparam logic [PROP_W-1:0] PROP_HEIGHT = 3'd3;
  localparam logic [PROP_W-1:0] PROP_EMPTY  = 3'd4;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic signed [15:0] coord_t;
  typedef logic [TIME_W-1:0]  ms_t;

endpackage

@@ src/arect_tween.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial tween unit
// from + (to - from) * elapsed / duration with truncation toward zero, by a
// 16-step shift-add multiply and a 16-step restoring divide on one register.
// Requires elapsed < duration.
// ----------------------------------------------------------------------------
module arect_tween (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  arect_pkg::coord_t from_i,
  input  arect_pkg::coord_t to_i,
  input  arect_pkg::ms_t   elapsed_i,
  input  arect_pkg::ms_t   duration_i,
  output logic             done_o,
  output arect_pkg::coord_t value_o
);
  import arect_pkg::*;

  localparam int MAG_W  = 16;
  localparam int PROD_W = TIME_W + MAG_W;
  localparam int CNT_W  = $clog2(MAG_W);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_MUL  = 2'd1;
  localparam logic [1:0] T_DIV  = 2'd2;
  localparam logic [1:0] T_DONE = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PROD_W-1:0] prod_q;
  ms_t               mcand_q, dvsr_q;
  coord_t            from_q;
  logic              neg_q;

  logic [MAG_W:0]    delta, delta_neg;
  logic [MAG_W-1:0]  mag, quot, quot_s;
  logic [TIME_W:0]   mul_sum, div_sh;
  logic [TIME_W+1:0] div_diff;
  logic              div_ge, last_step;

  always_comb begin
    delta     = {to_i[15], to_i} - {from_i[15], from_i};
    delta_neg = (MAG_W+1)'(0) - delta;
    mag       = delta[MAG_W] ? delta_neg[MAG_W-1:0] : delta[MAG_W-1:0];
    mul_sum   = {1'b0, prod_q[PROD_W-1:MAG_W]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
    div_sh    = {prod_q[PROD_W-1:MAG_W], prod_q[MAG_W-1]};
    div_diff  = {1'b0, div_sh} - {2'b00, dvsr_q};
    div_ge    = ~div_diff[TIME_W+1];
    quot      = prod_q[MAG_W-1:0];
    quot_s    = neg_q ? (~quot + MAG_W'(1)) : quot;
    last_step = (cnt_q == CNT_W'(MAG_W - 1));
  end

  assign value_o = from_q + coord_t'(quot_s);
  assign done_o  = (state_q == T_DONE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      T_IDLE: begin
        cnt_d = '0;
        if (go_i) state_d = T_MUL;
      end
      T_MUL: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (last_step) state_d = T_DIV;
      end
      T_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (last_step) state_d = T_DONE;
      end
      T_DONE: state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      T_IDLE: begin
        if (go_i) begin
          prod_q  <= {{TIME_W{1'b0}}, mag};
          mcand_q <= elapsed_i;
          dvsr_q  <= duration_i;
          from_q  <= from_i;
          neg_q   <= delta[MAG_W];
        end
      end
      T_MUL: prod_q <= {mul_sum, prod_q[MAG_W-1:1]};
      T_DIV: prod_q <= {div_ge ? div_diff[TIME_W-1:0] : div_sh[TIME_W-1:0],
                        prod_q[MAG_W-2:0], div_ge};
      default: prod_q <= prod_q;
    endcase
  end

endmodule

@@ src/animated_rect_evaluator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Animated rectangle evaluator
// Table of 16 animation slots and a serial query engine giving a node's
// animated rectangle at a given time.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken at a clock edge with start high and busy low.
//   cmd_i = write stores slot_i; busy stays low, no result.
//   cmd_i = query, for a node below node_count, walks all 16 slots in order and presents one result on
//   in_range_o / rect_*_o for exactly one cycle with done_o high.
//   Each slot that is skipped or already finished passes through a read and
//   a check state; a slot that needs interpolation also waits for the tween
//   unit (16-step multiply, 16-step divide and one done state). A node
//   outside node_count skips the walk and goes straight to the result.
//   Throughput is one query at a time; busy covers the whole walk and the
//   result cycle, so the next command is taken in the cycle after the strobe.
//   node_count is written through cfg_we_i / cfg_wdata_i; write it only while idle (not enforced by the block).
//   Reset empties every slot and clears node_count.
//   The receiver cannot stall: done_o is a one-cycle strobe.
// ----------------------------------------------------------------------------
module animated_rect_evaluator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cfg_we_i,
  input  logic [arect_pkg::NCNT_W-1:0]     cfg_wdata_i,
  input  logic                             cmd_i,
  input  logic [3:0]                       slot_i,
  input  logic [arect_pkg::NODE_W-1:0]     node_index_i,
  input  logic [arect_pkg::PROP_W-1:0]     property_code_i,
  input  arect_pkg::coord_t                from_value_i,
  input  arect_pkg::coord_t                to_value_i,
  input  arect_pkg::ms_t                   duration_ms_i,
  input  arect_pkg::ms_t                   time_value_i,
  input  arect_pkg::coord_t                base_x_i,
  input  arect_pkg::coord_t                base_y_i,
  input  arect_pkg::coord_t                base_width_i,
  input  arect_pkg::coord_t                base_height_i,
  output logic                             done_o,
  output logic                             in_range_o,
  output arect_pkg::coord_t                rect_x_o,
  output arect_pkg::coord_t                rect_y_o,
  output arect_pkg::coord_t                rect_width_o,
  output arect_pkg::coord_t                rect_height_o
);
  import arect_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [1:0] RIDX_X = PROP_X[1:0];
  localparam logic [1:0] RIDX_Y = PROP_Y[1:0];
  localparam logic [1:0] RIDX_W = PROP_WIDTH[1:0];
  localparam logic [1:0] RIDX_H = PROP_HEIGHT[1:0];

  logic [2:0]              state_q, state_d;
  logic [SLOT_W-1:0]       slot_cnt_q, slot_cnt_d;
  logic [NCNT_W-1:0]       node_count_q;
  logic [SLOTS-1:0]        vld_q;

  logic [NODE_W+PROP_W-1:0] np_mem [SLOTS];
  logic [31:0]              ft_mem [SLOTS];
  ms_t                      dly_mem [SLOTS];
  ms_t                      dur_mem [SLOTS];

  logic [NODE_W+PROP_W-1:0] rd_np_q;
  logic [31:0]              rd_ft_q;
  ms_t                      rd_dly_q, rd_dur_q;
  logic                     rd_vld_q;

  logic [NODE_W-1:0]       node_q;
  ms_t                     time_q;
  coord_t                  rect_q [4];
  logic                    in_range_q;

  logic                    accept, wr_en, query, node_ok;
  logic [PROP_W-1:0]       rd_prop;
  logic                    match, finished, last_slot, tw_go, tw_done;
  ms_t                     elapsed;
  coord_t                  tw_value;

  always_comb begin
    accept    = start && !busy;
    wr_en     = accept && (cmd_i == CMD_WRITE);
    query     = accept && (cmd_i == CMD_QUERY);
    node_ok   = {1'b0, node_index_i} < node_count_q;
    rd_prop   = rd_vld_q ? rd_np_q[NODE_W+PROP_W-1:NODE_W] : PROP_EMPTY;
    elapsed   = time_q - rd_dly_q;
    match     = (rd_prop <= PROP_HEIGHT) && (rd_np_q[NODE_W-1:0] == node_q)
                && (time_q >= rd_dly_q);
    finished  = elapsed >= rd_dur_q;
    last_slot = (slot_cnt_q == SLOT_W'(SLOTS - 1));
    tw_go     = (state_q == S_CHK) && match && !finished;
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = (state_q == S_DONE);
  assign in_range_o    = in_range_q;
  assign rect_x_o      = rect_q[RIDX_X];
  assign rect_y_o      = rect_q[RIDX_Y];
  assign rect_width_o  = rect_q[RIDX_W];
  assign rect_height_o = rect_q[RIDX_H];

  arect_tween u_tween (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (tw_go),
    .from_i     (coord_t'(rd_ft_q[15:0])),
    .to_i       (coord_t'(rd_ft_q[31:16])),
    .elapsed_i  (elapsed),
    .duration_i (rd_dur_q),
    .done_o     (tw_done),
    .value_o    (tw_value)
  );

  always_comb begin
    state_d    = state_q;
    slot_cnt_d = slot_cnt_q;
    unique case (state_q)
      S_IDLE: begin
        slot_cnt_d = '0;
        if (query) state_d = node_ok ? S_READ : S_DONE;
      end
      S_READ: state_d = S_CHK;
      S_CHK: begin
        if (!tw_go) begin
          state_d    = last_slot ? S_DONE : S_READ;
          slot_cnt_d = slot_cnt_q + SLOT_W'(1);
        end else begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (tw_done) begin
          state_d    = last_slot ? S_DONE : S_READ;
          slot_cnt_d = slot_cnt_q + SLOT_W'(1);
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      slot_cnt_q   <= '0;
      node_count_q <= '0;
      vld_q        <= '0;
    end else begin
      state_q    <= state_d;
      slot_cnt_q <= slot_cnt_d;
      if (cfg_we_i) node_count_q <= cfg_wdata_i;
      if (wr_en) vld_q[slot_i] <= 1'b1;
    end
  end

  // table storage with registered read at the walk pointer
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      np_mem[slot_i]  <= {property_code_i, node_index_i};
      ft_mem[slot_i]  <= {to_value_i, from_value_i};
      dly_mem[slot_i] <= time_value_i;
      dur_mem[slot_i] <= duration_ms_i;
    end
    rd_np_q  <= np_mem[slot_cnt_q];
    rd_ft_q  <= ft_mem[slot_cnt_q];
    rd_dly_q <= dly_mem[slot_cnt_q];
    rd_dur_q <= dur_mem[slot_cnt_q];
    rd_vld_q <= vld_q[slot_cnt_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_range_q <= 1'b0;
    end else if (query) begin
      in_range_q <= node_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query) begin
      node_q <= node_index_i;
      time_q <= time_value_i;
      if (node_ok) begin
        rect_q[RIDX_X] <= base_x_i;
        rect_q[RIDX_Y] <= base_y_i;
        rect_q[RIDX_W] <= base_width_i;
        rect_q[RIDX_H] <= base_height_i;
      end else begin
        rect_q[RIDX_X] <= '0;
        rect_q[RIDX_Y] <= '0;
        rect_q[RIDX_W] <= '0;
        rect_q[RIDX_H] <= '0;
      end
    end else if ((state_q == S_CHK) && match && finished) begin
      rect_q[rd_prop[1:0]] <= coord_t'(rd_ft_q[31:16]);
    end else if ((state_q == S_WAIT) && tw_done) begin
      rect_q[rd_prop[1:0]] <= tw_value;
    end
  end

endmodule

@@ src/arect_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Animated rectangle evaluator port checker
// Checks the command and result behavior seen on the top-level ports.
// ----------------------------------------------------------------------------
module arect_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              cmd_i,
  input logic              done_o,
  input logic              in_range_o,
  input arect_pkg::coord_t rect_x_o,
  input arect_pkg::coord_t rect_y_o,
  input arect_pkg::coord_t rect_width_o,
  input arect_pkg::coord_t rect_height_o
);
  import arect_pkg::*;

  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe outside a query");

  a_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i == CMD_WRITE)) |=> (!busy && !done_o))
    else $error("write transfer started work or gave a result");

  a_query_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i == CMD_QUERY)) |=> busy)
    else $error("query transfer did not start a walk");

  a_strobe_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_empty_rect : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !in_range_o) |-> (rect_x_o == 16'sd0 && rect_y_o == 16'sd0 &&
                                 rect_width_o == 16'sd0 && rect_height_o == 16'sd0))
    else $error("missing node gave a nonzero rectangle");

endmodule

bind animated_rect_evaluator arect_chk u_arect_chk (.*);
